// ===== rtl/dd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dd_pkg: shared types, constants and helpers for the date difference block
// Calendar tables, constant dividers and mod-7 reduction used by the pipeline.
// ----------------------------------------------------------------------------
package dd_pkg;

	localparam int YEAR_BITS = 12;
	// day ordinal of the last day of the widest year fits in YEAR_BITS + 9 bits
	localparam int ORD_BITS  = YEAR_BITS + 9;
	localparam int DAYS_BITS = 21;
	localparam int DIFF_BITS = (ORD_BITS > DAYS_BITS) ? ORD_BITS : DAYS_BITS;
	localparam logic [DAYS_BITS-1:0] DAYS_MAX = '1;

	localparam int MOFF_BITS = 9;
	localparam int LEN_BITS  = 5;
	localparam int DAY_BITS  = 8;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [2:0] WEEKDAY_SUN = 3'd6;

	// divide by 25 through a reciprocal, exact for any YEAR_BITS-bit value
	localparam int DIV_SHIFT    = YEAR_BITS + 5;
	localparam int DIV_MUL_BITS = YEAR_BITS + 1;
	localparam int DIV_P_BITS   = 2 * YEAR_BITS + 6;
	localparam logic [DIV_MUL_BITS-1:0] DIV25_MUL =
		DIV_MUL_BITS'(((64'd1 << DIV_SHIFT) + 64'd24) / 64'd25);

	// octal digits of an ordinal, for the mod-7 digit sum
	localparam int MOD7_DIGITS = (ORD_BITS + 2) / 3;

	typedef struct packed {
		logic [YEAR_BITS-1:0] year;
		logic [3:0]           month;
		logic [4:0]           day_or_week;
		logic [2:0]           weekday;
		logic                 by_weekday;
	} date_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	function automatic logic [YEAR_BITS-1:0] div25(input logic [YEAR_BITS-1:0] x);
		logic [DIV_P_BITS-1:0] p;
		p = DIV_P_BITS'(x) * DIV_P_BITS'(DIV25_MUL);
		return p[DIV_SHIFT +: YEAR_BITS];
	endfunction

	// reduce a value of at most 14 to 0..6
	function automatic logic [2:0] red7(input logic [3:0] t);
		logic [3:0] r;
		r = t;
		if (r >= 4'd7) r = r - 4'd7;
		if (r >= 4'd7) r = r - 4'd7;
		return r[2:0];
	endfunction

	// 8 is 1 mod 7, so the octal digit sum keeps the residue
	function automatic logic [2:0] mod7(input logic [ORD_BITS-1:0] x);
		logic [3*MOD7_DIGITS-1:0] xp;
		logic [7:0]               s;
		logic [3:0]               t;
		xp = (3*MOD7_DIGITS)'(x);
		s  = '0;
		for (int i = 0; i < MOD7_DIGITS; i++) begin
			s = s + 8'(xp[3*i +: 3]);
		end
		t = 4'(red7(4'(s[7:6]) + 4'(s[5:3]))) + 4'(s[2:0]);
		return red7(t);
	endfunction

	// days before the first of the month in a common year
	function automatic logic [MOFF_BITS-1:0] cum_days(input logic [3:0] m);
		logic [MOFF_BITS-1:0] d;
		unique case (m)
			4'd2:    d = MOFF_BITS'(31);
			4'd3:    d = MOFF_BITS'(59);
			4'd4:    d = MOFF_BITS'(90);
			4'd5:    d = MOFF_BITS'(120);
			4'd6:    d = MOFF_BITS'(151);
			4'd7:    d = MOFF_BITS'(181);
			4'd8:    d = MOFF_BITS'(212);
			4'd9:    d = MOFF_BITS'(243);
			4'd10:   d = MOFF_BITS'(273);
			4'd11:   d = MOFF_BITS'(304);
			4'd12:   d = MOFF_BITS'(334);
			default: d = '0;
		endcase
		return d;
	endfunction

	function automatic logic [LEN_BITS-1:0] month_len(input logic [3:0] m);
		logic [LEN_BITS-1:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = LEN_BITS'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    d = LEN_BITS'(30);
			4'd2:                                       d = LEN_BITS'(28);
			default:                                    d = '0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dd_in_if: input channel carrying a pair of dates
// Valid/ready handshake with both dates as payload.
// ----------------------------------------------------------------------------
interface dd_in_if;
	import dd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [YEAR_BITS-1:0] first_year;
	logic [3:0]           first_month;
	logic [4:0]           first_day_or_week;
	logic [2:0]           first_weekday;
	logic                 first_by_weekday;
	logic [YEAR_BITS-1:0] second_year;
	logic [3:0]           second_month;
	logic [4:0]           second_day_or_week;
	logic [2:0]           second_weekday;
	logic                 second_by_weekday;

	modport source (
		output valid, first_year, first_month, first_day_or_week, first_weekday,
			first_by_weekday, second_year, second_month, second_day_or_week,
			second_weekday, second_by_weekday,
		input  ready
	);

	modport sink (
		input  valid, first_year, first_month, first_day_or_week, first_weekday,
			first_by_weekday, second_year, second_month, second_day_or_week,
			second_weekday, second_by_weekday,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/dd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dd_out_if: result channel
// Valid/ready handshake carrying the day difference and the invalid flag.
// ----------------------------------------------------------------------------
interface dd_out_if;
	import dd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DAYS_BITS-1:0] days_between;
	logic                 invalid;

	modport source (
		output valid, days_between, invalid,
		input  ready
	);

	modport sink (
		input  valid, days_between, invalid,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/dd_date_ord.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dd_date_ord: four-stage day ordinal datapath for one date
// Turns a date (by day or by Nth weekday) into its ordinal and a valid flag.
// ----------------------------------------------------------------------------
module dd_date_ord (
	input  logic                          clk,
	input  dd_pkg::date_t                 date,
	input  dd_pkg::stage_en_t             en,
	output logic [dd_pkg::ORD_BITS-1:0]   ord,
	output logic                          ok
);
	import dd_pkg::*;

	// stage 1: year terms through constant dividers
	logic [YEAR_BITS-1:0] n_c;
	logic                 ok_c;
	logic [YEAR_BITS-1:0] y_s1, n_s1, q100_s1, q400_s1, qy4_s1, qy16_s1;
	logic [3:0]           m_s1;
	logic [4:0]           dw_s1;
	logic [2:0]           wd_s1;
	logic                 bw_s1, ok_s1;

	assign n_c  = date.year - YEAR_BITS'(1);
	assign ok_c = (date.year != '0) && (date.month != 4'd0) && (date.month <= MONTH_DEC);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			y_s1    <= date.year;
			n_s1    <= n_c;
			q100_s1 <= div25(n_c >> 2);
			q400_s1 <= div25(n_c >> 4);
			qy4_s1  <= div25(date.year >> 2);
			qy16_s1 <= div25(date.year >> 4);
			m_s1    <= date.month;
			dw_s1   <= date.day_or_week;
			wd_s1   <= date.weekday;
			bw_s1   <= date.by_weekday;
			ok_s1   <= ok_c;
		end
	end

	// stage 2: leap year, days before the year and before the month
	logic                 not_cent, quad_cent, leap;
	logic [ORD_BITS-1:0]  ydays_s2;
	logic [MOFF_BITS-1:0] moff_s2;
	logic [LEN_BITS-1:0]  len_s2;
	logic [4:0]           dw_s2;
	logic [2:0]           wd_s2;
	logic                 bw_s2, ok_s2;

	assign not_cent  = YEAR_BITS'(qy4_s1 * YEAR_BITS'(25)) != (y_s1 >> 2);
	assign quad_cent = YEAR_BITS'(qy16_s1 * YEAR_BITS'(25)) == (y_s1 >> 4);
	assign leap      = ((y_s1[1:0] == 2'd0) && not_cent) || ((y_s1[3:0] == 4'd0) && quad_cent);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ydays_s2 <= ORD_BITS'(n_s1) * ORD_BITS'(365) + ORD_BITS'(n_s1 >> 2)
				- ORD_BITS'(q100_s1) + ORD_BITS'(q400_s1);
			moff_s2  <= cum_days(m_s1) + MOFF_BITS'(leap && (m_s1 >= MONTH_MAR));
			len_s2   <= month_len(m_s1) + LEN_BITS'(leap && (m_s1 == MONTH_FEB));
			dw_s2    <= dw_s1;
			wd_s2    <= wd_s1;
			bw_s2    <= bw_s1;
			ok_s2    <= ok_s1;
		end
	end

	// stage 3: month base ordinal and weekday of its first day
	logic [ORD_BITS-1:0] base_s3;
	logic [2:0]          fw_s3;
	logic [LEN_BITS-1:0] len_s3;
	logic [4:0]          dw_s3;
	logic [2:0]          wd_s3;
	logic                bw_s3, ok_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			base_s3 <= ydays_s2 + ORD_BITS'(moff_s2);
			fw_s3   <= red7(4'(mod7(ydays_s2)) + 4'(mod7(ORD_BITS'(moff_s2))));
			len_s3  <= len_s2;
			dw_s3   <= dw_s2;
			wd_s3   <= wd_s2;
			bw_s3   <= bw_s2;
			ok_s3   <= ok_s2;
		end
	end

	// stage 4: day of month, range check, final ordinal
	logic [2:0]          off;
	logic [DAY_BITS-1:0] day_wd, day;
	logic                bad_wd, ok_c4;

	assign off    = red7(4'(wd_s3) + 4'd7 - 4'(fw_s3));
	assign day_wd = DAY_BITS'(1) + DAY_BITS'(off)
		+ DAY_BITS'(DAY_BITS'(7) * (DAY_BITS'(dw_s3) - DAY_BITS'(1)));
	assign day    = bw_s3 ? day_wd : DAY_BITS'(dw_s3);
	assign bad_wd = bw_s3 && ((wd_s3 > WEEKDAY_SUN) || (dw_s3 == 5'd0));
	assign ok_c4  = ok_s3 && !bad_wd && (day != '0) && (day <= DAY_BITS'(len_s3));

	always_ff @(posedge clk) begin
		if (en.s4) begin
			ord <= base_s3 + ORD_BITS'(day);
			ok  <= ok_c4;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/date_difference_days.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// date_difference_days: absolute day count between two Gregorian dates
// Five-stage pipeline with valid bits and per-stage stall control.
// ----------------------------------------------------------------------------
// usage
//   dates  : sink channel, two dates per transaction; each date is either
//            year-month-day or year-month plus week number and weekday
//   result : source channel, days_between and invalid per transaction
//   path   : an accepted transaction passes stages 1 to 5 in order before
//            result.valid, the last stage being the output register
//   rate   : one transaction per cycle unless a low result.ready holds the
//            pipeline; no stage works on an item iteratively
//   stall  : each stage loads whenever it is empty or the one after it moves,
//            so bubbles close up and dates.ready only drops once all five
//            stages are full with result.ready low
//   reset  : arst_n clears the valid bits only; the datapath registers are not reset
//   invalid: either date missing from the calendar gives invalid high and a
//            zero day count
// ----------------------------------------------------------------------------
module date_difference_days (
	input  logic     clk,
	input  logic     arst_n,
	dd_in_if.sink    dates,
	dd_out_if.source result
);
	import dd_pkg::*;

	date_t               date_a, date_b;
	stage_en_t           en;
	logic                en_s1, en_s2, en_s3, en_s4, en_s5;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ORD_BITS-1:0] ord_a, ord_b;
	logic                ok_a, ok_b;

	assign date_a = '{
		year:        dates.first_year,
		month:       dates.first_month,
		day_or_week: dates.first_day_or_week,
		weekday:     dates.first_weekday,
		by_weekday:  dates.first_by_weekday
	};
	assign date_b = '{
		year:        dates.second_year,
		month:       dates.second_month,
		day_or_week: dates.second_day_or_week,
		weekday:     dates.second_weekday,
		by_weekday:  dates.second_by_weekday
	};

	// a stage moves when it is empty or its successor moves
	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign en = '{s1: en_s1, s2: en_s2, s3: en_s3, s4: en_s4};

	assign dates.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= dates.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// both dates travel in lockstep under the same stage enables
	dd_date_ord u_ord_a (
		.clk  (clk),
		.date (date_a),
		.en   (en),
		.ord  (ord_a),
		.ok   (ok_a)
	);

	dd_date_ord u_ord_b (
		.clk  (clk),
		.date (date_b),
		.en   (en),
		.ord  (ord_b),
		.ok   (ok_b)
	);

	// stage 5: absolute difference, saturated to the output width
	logic [DIFF_BITS-1:0] diff;
	logic [DAYS_BITS-1:0] days_c;
	logic [DAYS_BITS-1:0] days_s5;
	logic                 invalid_s5;

	assign diff = (ord_a > ord_b) ? DIFF_BITS'(ord_a - ord_b) : DIFF_BITS'(ord_b - ord_a);

	always_comb begin
		if (!(ok_a && ok_b)) begin
			days_c = '0;
		end else if (diff > DIFF_BITS'(DAYS_MAX)) begin
			days_c = DAYS_MAX;
		end else begin
			days_c = DAYS_BITS'(diff);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			days_s5    <= days_c;
			invalid_s5 <= !(ok_a && ok_b);
		end
	end

	assign result.valid        = v_s5;
	assign result.days_between = days_s5;
	assign result.invalid      = invalid_s5;

endmodule
`default_nettype wire
